### hdl/lsnim_pkg.sv
// Shared types and constants for the lattice site / node index mapper.
// Used by lsnim_cfg and the core module; depends on nothing else.
package lsnim_pkg;

  localparam int DIMS        = 4;
  localparam int COORD_W     = 12;
  localparam int WORD_W      = 24;
  localparam int REG_W       = 7;
  localparam int HALF_W      = REG_W - 1;
  localparam int EXTENT_BITS = 6;
  localparam int COLORS      = 32;
  localparam int CLR_W       = $clog2(COLORS);
  localparam int SITES_W     = DIMS * REG_W;
  localparam int SUB_W       = SITES_W - CLR_W;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  localparam logic [8:0]       EXT_MAX     = 9'(1 << EXTENT_BITS);
  localparam logic [REG_W-1:0] EXT_MIN     = REG_W'(2);
  localparam logic [REG_W-1:0] NODES_MIN   = REG_W'(1);
  localparam logic [REG_W-1:0] NODES_MAX   = REG_W'(64);
  localparam logic [REG_W-1:0] EXT_RESET   = REG_W'(2);
  localparam logic [REG_W-1:0] NODES_RESET = REG_W'(1);

  // Register map: extents first, then node counts, x fastest.
  localparam int REG_EXT_BASE   = 0;
  localparam int REG_NODES_BASE = DIMS;
  localparam int NUM_REGS       = 2 * DIMS;

  localparam logic ACT_TO_INDEX = 1'b0;
  localparam logic ACT_TO_SITE  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [COORD_W-1:0] coord_t;
    logic [WORD_W-1:0]  node_in;
    logic [WORD_W-1:0]  index_in;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  node_out;
    logic [WORD_W-1:0]  index_out;
    logic [COORD_W-1:0] site_x;
    logic [COORD_W-1:0] site_y;
    logic [COORD_W-1:0] site_z;
    logic [COORD_W-1:0] site_t;
    logic               out_of_range;
  } out_t;

  typedef struct packed {
    logic [DIMS-1:0][REG_W-1:0]   ext;
    logic [DIMS-1:0][REG_W-1:0]   nod;
    logic [DIMS-1:0][HALF_W-1:0]  half;
    logic [DIMS-1:0][2*REG_W-1:0] span;
    logic [2*HALF_W-1:0]          hxy;
    logic [3*HALF_W-1:0]          hxyz;
    logic [2*REG_W-1:0]           nxy;
    logic [3*REG_W-1:0]           nxyz;
    logic [SITES_W-1:0]           count;
    logic [SITES_W-1:0]           sites;
    logic [SUB_W-1:0]             sub;
    logic                         ok;
  } cfg_t;

endpackage

### hdl/lsnim_delay.sv
// Shift register of N stages, advanced only while en is high, that delays a bus.
// Depends on nothing.
module lsnim_delay #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] stage [N];

  always_ff @(posedge clk) begin
    if (en) begin
      stage[0] <= din;
      for (int i = 1; i < N; i++) begin
        stage[i] <= stage[i-1];
      end
    end
  end

  assign dout = stage[N-1];

endmodule

### hdl/lsnim_div.sv
// Pipelined restoring divider, one quotient bit per stage, all stages enabled together.
// Depends on nothing. The quotient must fit in QW bits.
module lsnim_div #(
  parameter int NW = 24,
  parameter int DW = 7,
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quot,
  output logic [NW-1:0] rem
);

  localparam int W = NW + DW;

  logic [W-1:0]  r_s [QW];
  logic [DW-1:0] d_s [QW];
  logic [QW-1:0] q_s [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    localparam int K = QW - 1 - i;
    logic [W-1:0]  r_prev;
    logic [DW-1:0] d_prev;
    logic [QW-1:0] q_prev;
    logic [W-1:0]  trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign r_prev = W'(num);
      assign d_prev = den;
      assign q_prev = '0;
    end else begin : g_next
      assign r_prev = r_s[i-1];
      assign d_prev = d_s[i-1];
      assign q_prev = q_s[i-1];
    end

    assign trial = W'(d_prev) << K;
    assign ge    = (r_prev >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[i] <= ge ? (r_prev - trial) : r_prev;
        d_s[i] <= d_prev;
        q_s[i] <= (q_prev << 1) | QW'(ge);
      end
    end
  end

  assign quot = q_s[QW-1];
  assign rem  = r_s[QW-1][NW-1:0];

endmodule

### hdl/lsnim_cfg.sv
// Configuration registers behind the APB-style port, plus derived layout values.
// Depends on lsnim_pkg. Derived values are registered, with sub and ok settling last.
module lsnim_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsnim_pkg::ADDR_W-1:0] paddr,
  input  logic [lsnim_pkg::DATA_W-1:0] pwdata,
  output logic [lsnim_pkg::DATA_W-1:0] prdata,
  output lsnim_pkg::cfg_t              cfg
);

  localparam int RW = lsnim_pkg::REG_W;
  localparam int HW = lsnim_pkg::HALF_W;
  localparam int SW = lsnim_pkg::SITES_W;

  logic [RW-1:0] regs [lsnim_pkg::NUM_REGS];
  logic [lsnim_pkg::DIMS-1:0][RW-1:0] ext;
  logic [lsnim_pkg::DIMS-1:0][RW-1:0] nod;
  logic [lsnim_pkg::DIMS-1:0][HW-1:0] half;
  logic rng_ok;

  logic [lsnim_pkg::DIMS-1:0][2*RW-1:0] span;
  logic [2*RW-1:0] exy;
  logic [2*RW-1:0] ezt;
  logic [2*RW-1:0] nxy;
  logic [2*RW-1:0] nzt;
  logic [2*HW-1:0] hxy;
  logic            ok1;

  logic [SW-1:0]   sites;
  logic [SW-1:0]   count;
  logic [3*RW-1:0] nxyz;
  logic [3*HW-1:0] hxyz;
  logic            ok2;

  logic                          ok3;
  logic [lsnim_pkg::SUB_W-1:0]   sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lsnim_pkg::DIMS; i++) begin
        regs[lsnim_pkg::REG_EXT_BASE + i]   <= lsnim_pkg::EXT_RESET;
        regs[lsnim_pkg::REG_NODES_BASE + i] <= lsnim_pkg::NODES_RESET;
      end
    end else if (psel && penable && pwrite) begin
      regs[paddr[lsnim_pkg::ADDR_W-1:2]] <= pwdata[RW-1:0];
    end
  end

  assign prdata = lsnim_pkg::DATA_W'(regs[paddr[lsnim_pkg::ADDR_W-1:2]]);

  always_comb begin
    rng_ok = 1'b1;
    for (int d = 0; d < lsnim_pkg::DIMS; d++) begin
      ext[d]  = regs[lsnim_pkg::REG_EXT_BASE + d];
      nod[d]  = regs[lsnim_pkg::REG_NODES_BASE + d];
      half[d] = ext[d][RW-1:1];
      if (ext[d] < lsnim_pkg::EXT_MIN || 9'(ext[d]) > lsnim_pkg::EXT_MAX || ext[d][0]) begin
        rng_ok = 1'b0;
      end
      if (nod[d] < lsnim_pkg::NODES_MIN || nod[d] > lsnim_pkg::NODES_MAX) begin
        rng_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int d = 0; d < lsnim_pkg::DIMS; d++) begin
      span[d] <= (2*RW)'(ext[d]) * (2*RW)'(nod[d]);
    end
    exy <= (2*RW)'(ext[0]) * (2*RW)'(ext[1]);
    ezt <= (2*RW)'(ext[2]) * (2*RW)'(ext[3]);
    nxy <= (2*RW)'(nod[0]) * (2*RW)'(nod[1]);
    nzt <= (2*RW)'(nod[2]) * (2*RW)'(nod[3]);
    hxy <= (2*HW)'(half[0]) * (2*HW)'(half[1]);
    ok1 <= rng_ok;

    sites <= SW'(exy) * SW'(ezt);
    count <= SW'(nxy) * SW'(nzt);
    nxyz  <= (3*RW)'(nxy) * (3*RW)'(nod[2]);
    hxyz  <= (3*HW)'(hxy) * (3*HW)'(half[2]);
    ok2   <= ok1;

    ok3 <= ok2 && ((sites % lsnim_pkg::COLORS) == '0);
    sub <= lsnim_pkg::SUB_W'(sites / lsnim_pkg::COLORS);
  end

  always_comb begin
    cfg.ext   = ext;
    cfg.nod   = nod;
    cfg.half  = half;
    cfg.span  = span;
    cfg.hxy   = hxy;
    cfg.hxyz  = hxyz;
    cfg.nxy   = nxy;
    cfg.nxyz  = nxyz;
    cfg.count = count;
    cfg.sites = sites;
    cfg.sub   = sub;
    cfg.ok    = ok3;
  end

endmodule

### hdl/lattice_site_node_index_map_core.sv
// Lattice site to node/index mapper and its inverse, fully pipelined.
// Depends on lsnim_pkg, lsnim_cfg, lsnim_div and lsnim_delay.
//
// Requests arrive on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; a request is taken at a clock edge with
// valid high and stall low. Action 0 maps a global coordinate to its node
// and color-ordered index; action 1 maps node and index back to a site.
// Out-of-lattice requests and any request under an invalid layout return
// out_of_range with all other fields zero.
// One request is taken every cycle while in_stall is low; the pipeline
// depth is set by the index-to-color divider followed by the 24-bit
// position dividers, one quotient bit per stage.
// All stages advance together. When the receiver stalls, the output
// register holds its result and one more result lands in a skid register;
// in_stall rises only while that skid register is occupied.
// Reset (rst, synchronous) empties the pipeline and sets extents to 2 and
// node counts to 1, which is an invalid layout. Configuration writes must
// come while no request is in flight.
module lattice_site_node_index_map_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lsnim_pkg::in_t               in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lsnim_pkg::out_t              out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsnim_pkg::ADDR_W-1:0] paddr,
  input  logic [lsnim_pkg::DATA_W-1:0] pwdata,
  output logic [lsnim_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int DIMS  = lsnim_pkg::DIMS;
  localparam int CW    = lsnim_pkg::COORD_W;
  localparam int WW    = lsnim_pkg::WORD_W;
  localparam int RW    = lsnim_pkg::REG_W;
  localparam int HW    = lsnim_pkg::HALF_W;
  localparam int KW    = lsnim_pkg::CLR_W;
  localparam int SW    = lsnim_pkg::SITES_W;
  localparam int FRONT = 4;
  localparam int FDIV  = CW;
  localparam int CDIV  = KW;
  localparam int WDIV  = WW;
  localparam int FDONE = FDIV + 4;
  localparam int LAT   = CDIV + WDIV + 3;
  localparam int TOT   = FRONT + LAT;

  lsnim_pkg::cfg_t cfg;
  lsnim_pkg::in_t  in_r;
  lsnim_pkg::in_t  p0;
  lsnim_pkg::out_t res;
  lsnim_pkg::out_t skid;

  logic           adv;
  logic           skid_v;
  logic [TOT-1:0] vld;

  assign pready   = 1'b1;
  assign adv      = !skid_v;
  assign in_stall = skid_v;

  lsnim_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_r <= in_data;
    end
  end

  // The extra front stages give derived layout values time to settle after a write.
  lsnim_delay #(.W($bits(lsnim_pkg::in_t)), .N(FRONT-1)) u_front (
    .clk (clk), .en (adv), .din (in_r), .dout (p0)
  );

  // ---------------- range checks ----------------
  logic [CW-1:0] crd [DIMS];
  logic          oor_f;
  logic          oor_i;
  logic [1:0]    flags_l;
  logic [KW-1:0] color_f;

  always_comb begin
    crd[0] = p0.coord_x;
    crd[1] = p0.coord_y;
    crd[2] = p0.coord_z;
    crd[3] = p0.coord_t;
    oor_f  = 1'b0;
    for (int d = 0; d < DIMS; d++) begin
      if ((2*RW)'(crd[d]) >= cfg.span[d]) begin
        oor_f = 1'b1;
      end
    end
    oor_i = (SW'(p0.node_in) >= cfg.count) || (SW'(p0.index_in) >= cfg.sites);
    // Color: low coordinate bits, plus parity of the halved coordinates on top.
    color_f = {crd[0][1] ^ crd[1][1] ^ crd[2][1] ^ crd[3][1],
               crd[3][0], crd[2][0], crd[1][0], crd[0][0]};
  end

  lsnim_delay #(.W(2), .N(LAT)) u_flags (
    .clk  (clk),
    .en   (adv),
    .din  ({p0.action, (p0.action == lsnim_pkg::ACT_TO_SITE) ? oor_i : oor_f}),
    .dout (flags_l)
  );

  // ---------------- forward path ----------------
  logic [CW-1:0]   fq [DIMS];
  logic [CW-1:0]   fr [DIMS];
  logic [KW-1:0]   col_f;

  for (genvar d = 0; d < DIMS; d++) begin : g_fdiv
    lsnim_div #(.NW(CW), .DW(RW), .QW(CW)) u_fdiv (
      .clk (clk), .en (adv), .num (crd[d]), .den (cfg.ext[d]),
      .quot (fq[d]), .rem (fr[d])
    );
  end

  lsnim_delay #(.W(KW), .N(FDIV)) u_fcol (
    .clk (clk), .en (adv), .din (color_f), .dout (col_f)
  );

  logic [2*RW-1:0] f1_n;
  logic [2*HW-1:0] f1_l;
  logic [RW-1:0]   f1_q0, f1_q1, f2_q0;
  logic [HW-1:0]   f1_h0, f1_h1, f2_h0;
  logic [SW-1:0]   f1_cs, f2_cs, f3_cs;
  logic [3*RW-1:0] f2_n;
  logic [3*HW-1:0] f2_l;
  logic [SW-1:0]   f3_n;
  logic [WW-1:0]   f3_l;
  logic [WW-1:0]   f4_node, f4_idx;
  logic [WW-1:0]   fl_node, fl_idx;

  // Node number and lexicographic half-site index, t slowest; t with z, then y, x.
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_n  <= (2*RW)'(fq[3][RW-1:0]) * (2*RW)'(cfg.nod[2]) + (2*RW)'(fq[2][RW-1:0]);
      f1_l  <= (2*HW)'(fr[3][RW-1:1]) * (2*HW)'(cfg.half[2]) + (2*HW)'(fr[2][RW-1:1]);
      f1_q1 <= fq[1][RW-1:0];
      f1_q0 <= fq[0][RW-1:0];
      f1_h1 <= fr[1][RW-1:1];
      f1_h0 <= fr[0][RW-1:1];
      f1_cs <= SW'(col_f) * SW'(cfg.sub);

      f2_n  <= (3*RW)'(f1_n) * (3*RW)'(cfg.nod[1]) + (3*RW)'(f1_q1);
      f2_l  <= (3*HW)'(f1_l) * (3*HW)'(cfg.half[1]) + (3*HW)'(f1_h1);
      f2_q0 <= f1_q0;
      f2_h0 <= f1_h0;
      f2_cs <= f1_cs;

      f3_n  <= SW'(f2_n) * SW'(cfg.nod[0]) + SW'(f2_q0);
      f3_l  <= WW'(f2_l) * WW'(cfg.half[0]) + WW'(f2_h0);
      f3_cs <= f2_cs;

      f4_node <= f3_n[WW-1:0];
      f4_idx  <= (f3_l >> 1) + f3_cs[WW-1:0];
    end
  end

  lsnim_delay #(.W(2*WW), .N(LAT-FDONE)) u_fwd (
    .clk (clk), .en (adv), .din ({f4_node, f4_idx}), .dout ({fl_node, fl_idx})
  );

  // ---------------- inverse path ----------------
  logic [KW-1:0]   cq;
  logic [WW-1:0]   crem;
  logic [WW-1:0]   pos;
  logic [WW-1:0]   pq [3];
  logic [WW-1:0]   nq [3];
  logic [3*WW-1:0] nq_d;
  logic [WW-1:0]   nd;
  logic [WW-1:0]   pd;
  logic [KW-1:0]   cqd;

  lsnim_div #(.NW(WW), .DW(lsnim_pkg::SUB_W), .QW(KW)) u_cdiv (
    .clk (clk), .en (adv), .num (p0.index_in), .den (cfg.sub), .quot (cq), .rem (crem)
  );

  assign pos = WW'({crem[lsnim_pkg::SUB_W-1:0], 1'b0});

  lsnim_div #(.NW(WW), .DW(HW), .QW(WW)) u_pdiv0 (
    .clk (clk), .en (adv), .num (pos), .den (cfg.half[0]), .quot (pq[0]), .rem ()
  );
  lsnim_div #(.NW(WW), .DW(2*HW), .QW(WW)) u_pdiv1 (
    .clk (clk), .en (adv), .num (pos), .den (cfg.hxy), .quot (pq[1]), .rem ()
  );
  lsnim_div #(.NW(WW), .DW(3*HW), .QW(WW)) u_pdiv2 (
    .clk (clk), .en (adv), .num (pos), .den (cfg.hxyz), .quot (pq[2]), .rem ()
  );

  lsnim_div #(.NW(WW), .DW(RW), .QW(WW)) u_ndiv0 (
    .clk (clk), .en (adv), .num (p0.node_in), .den (cfg.nod[0]), .quot (nq[0]), .rem ()
  );
  lsnim_div #(.NW(WW), .DW(2*RW), .QW(WW)) u_ndiv1 (
    .clk (clk), .en (adv), .num (p0.node_in), .den (cfg.nxy), .quot (nq[1]), .rem ()
  );
  lsnim_div #(.NW(WW), .DW(3*RW), .QW(WW)) u_ndiv2 (
    .clk (clk), .en (adv), .num (p0.node_in), .den (cfg.nxyz), .quot (nq[2]), .rem ()
  );

  lsnim_delay #(.W(3*WW), .N(CDIV)) u_nqd (
    .clk (clk), .en (adv), .din ({nq[2], nq[1], nq[0]}), .dout (nq_d)
  );
  lsnim_delay #(.W(WW), .N(CDIV+WDIV)) u_nd (
    .clk (clk), .en (adv), .din (p0.node_in), .dout (nd)
  );
  lsnim_delay #(.W(WW), .N(WDIV)) u_pd (
    .clk (clk), .en (adv), .din (pos), .dout (pd)
  );
  lsnim_delay #(.W(KW), .N(WDIV)) u_cqd (
    .clk (clk), .en (adv), .din (cq), .dout (cqd)
  );

  logic [HW-1:0] ih  [DIMS];
  logic [HW-1:0] fh  [DIMS];
  logic [HW-1:0] ih2 [DIMS];
  logic [RW-1:0] imc  [DIMS];
  logic [RW-1:0] imc2 [DIMS];
  logic [KW-1:0] icol, icol2;
  logic [CW-1:0] st [DIMS];

  // Mixed-radix digits recovered from quotients by successive products.
  always_ff @(posedge clk) begin
    if (adv) begin
      ih[0]  <= HW'(pd - WW'(pq[0]) * WW'(cfg.half[0]));
      ih[1]  <= HW'(pq[0] - pq[1] * WW'(cfg.half[1]));
      ih[2]  <= HW'(pq[1] - pq[2] * WW'(cfg.half[2]));
      ih[3]  <= pq[2][HW-1:0];
      imc[0] <= RW'(nd - nq_d[WW-1:0] * WW'(cfg.nod[0]));
      imc[1] <= RW'(nq_d[WW-1:0] - nq_d[2*WW-1:WW] * WW'(cfg.nod[1]));
      imc[2] <= RW'(nq_d[2*WW-1:WW] - nq_d[3*WW-1:2*WW] * WW'(cfg.nod[2]));
      imc[3] <= nq_d[2*WW+RW-1:2*WW];
      icol   <= cqd;
    end
  end

  // When the digit parity disagrees with the color's parity bit, step the
  // position by one with carry from x towards t.
  always_comb begin
    logic       carry;
    logic [RW-1:0] t;
    carry = (ih[0][0] ^ ih[1][0] ^ ih[2][0] ^ ih[3][0]) != icol[KW-1];
    t     = '0;
    for (int d = 0; d < DIMS; d++) begin
      fh[d] = ih[d];
      if (carry) begin
        t = RW'(ih[d]) + RW'(1);
        if (d == DIMS - 1 || t < RW'(cfg.half[d])) begin
          fh[d] = t[HW-1:0];
          carry = 1'b0;
        end else begin
          fh[d] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < DIMS; d++) begin
        ih2[d]  <= fh[d];
        imc2[d] <= imc[d];
        st[d]   <= CW'({ih2[d], icol2[d]}) + CW'(CW'(imc2[d]) * CW'(cfg.ext[d]));
      end
      icol2 <= icol;
    end
  end

  // ---------------- result and output registers ----------------
  always_comb begin
    res = '0;
    if (!cfg.ok || flags_l[0]) begin
      res.out_of_range = 1'b1;
    end else if (flags_l[1] == lsnim_pkg::ACT_TO_SITE) begin
      res.site_x = st[0];
      res.site_y = st[1];
      res.site_z = st[2];
      res.site_t = st[3];
    end else begin
      res.node_out  = fl_node;
      res.index_out = fl_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (adv) begin
      if (vld[TOT-1]) begin
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end else if (!out_stall) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[TOT-1] && (!out_valid || !out_stall)) begin
      out_data <= res;
    end
    if (adv && vld[TOT-1] && out_valid && out_stall) begin
      skid <= res;
    end
    if (!adv && !out_stall) begin
      out_data <= skid;
    end
  end

endmodule
